FILE: rtl/moving_average_filter_macros.svh
// assertion macros for the moving average filter
`ifndef MOVING_AVERAGE_FILTER_MACROS_SVH
`define MOVING_AVERAGE_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define MAF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("moving average filter check failed");
`define MAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("moving average filter check failed");
`else
`define MAF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MAF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/maf_pkg.sv
// shared types and constants for the moving average filter
package maf_pkg;

  localparam int MAF_SAMPLE_W   = 16;
  localparam int MAF_CNT_W      = 7;
  localparam int MAF_APB_DW     = 32;
  localparam int MAF_ADDR_W     = 3;
  localparam int MAF_MAX_WINDOW = 64;

  localparam logic [MAF_CNT_W-1:0] MAF_LEN_RESET = MAF_CNT_W'(8);

  localparam logic [MAF_ADDR_W-3:0] MAF_REG_WINDOW_LENGTH = '0;

  localparam logic MAF_KIND_ADD   = 1'b0;
  localparam logic MAF_KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic                           kind;
    logic signed [MAF_SAMPLE_W-1:0] sample;
  } maf_in_t;

  typedef struct packed {
    logic signed [MAF_SAMPLE_W-1:0] average;
    logic                           window_full;
    logic [MAF_CNT_W-1:0]           samples_held;
  } maf_out_t;

endpackage

FILE: rtl/maf_div.sv
// bit-serial restoring divider, unsigned dividend by unsigned count
module maf_div #(
  parameter int DVD_W = 22
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DVD_W-1:0]              dividend,
  input  logic [maf_pkg::MAF_CNT_W-1:0] divisor,
  output logic                          done,
  output logic [DVD_W-1:0]              quotient
);
  import maf_pkg::*;

  localparam int IT_W = $clog2(DVD_W + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [IT_W-1:0]      iter_r, iter_nxt;
  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [MAF_CNT_W-1:0] rem_r, rem_nxt;
  logic [MAF_CNT_W-1:0] dsr_r, dsr_nxt;
  logic [MAF_CNT_W:0]   shifted;
  logic [MAF_CNT_W:0]   diff;
  logic                 ge;
  logic                 last;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};
  assign last    = iter_r == IT_W'(DVD_W - 1);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[MAF_CNT_W-1:0] : shifted[MAF_CNT_W-1:0];
      quo_nxt  = {quo_r[DVD_W-2:0], ge};
      iter_nxt = iter_r + IT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/moving_average_filter.sv
// moving average filter top level: sample ring, running sum, sequencer, apb register
// an add request steps through the read, update, start, divide and finish states after acceptance,
// the divide state held while the bit-serial divider takes one quotient bit per cycle
// a clear request goes straight to the finish state; both register their result there once the output is free
// one request at a time: the next request is taken the cycle after the result is registered
// reset: window length 8, ring empty; held count gates old-entry reads, no clearing pass
`include "moving_average_filter_macros.svh"

module moving_average_filter #(
  parameter int MAX_WINDOW = maf_pkg::MAF_MAX_WINDOW
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  maf_pkg::maf_in_t                 in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output maf_pkg::maf_out_t                out_item,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [maf_pkg::MAF_ADDR_W-1:0]   paddr,
  input  logic [maf_pkg::MAF_APB_DW-1:0]   pwdata,
  output logic [maf_pkg::MAF_APB_DW-1:0]   prdata,
  output logic                             pready
);
  import maf_pkg::*;

  localparam int LEN_CAP = 2 ** MAF_CNT_W - 1;
  localparam int CNT_MAX = (MAX_WINDOW < LEN_CAP) ? MAX_WINDOW : LEN_CAP;
  localparam int SUM_W   = MAF_SAMPLE_W + $clog2(CNT_MAX);
  localparam int PTR_W   = $clog2(MAX_WINDOW);
  localparam int CMP_W   = (PTR_W + 1 > MAF_CNT_W) ? PTR_W + 1 : MAF_CNT_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [MAF_CNT_W-1:0]           window_length_r;
  logic [MAF_CNT_W-1:0]           active_len_r, active_len_nxt;
  logic [MAF_CNT_W-1:0]           count_r, count_nxt;
  logic [PTR_W-1:0]               ptr_r, ptr_nxt;
  logic signed [SUM_W-1:0]        sum_r, sum_nxt;
  logic signed [MAF_SAMPLE_W-1:0] sample_r, sample_nxt;
  logic signed [MAF_SAMPLE_W-1:0] avg_r, avg_nxt;
  logic                           neg_r, neg_nxt;
  logic                           out_valid_r, out_valid_nxt;
  maf_out_t                       out_item_r, out_item_nxt;

  logic signed [MAF_SAMPLE_W-1:0] store_r [MAX_WINDOW];
  logic signed [MAF_SAMPLE_W-1:0] rd_data_r;
  logic signed [MAF_SAMPLE_W-1:0] old_entry;
  logic [MAF_CNT_W-1:0]           len_latched;
  logic [CMP_W-1:0]               ptr_inc;
  logic [SUM_W-1:0]               sum_mag;
  logic                           div_start;
  logic                           div_done;
  logic [SUM_W-1:0]               div_quo;
  logic [MAF_SAMPLE_W-1:0]        quo_low;
  logic                           in_fire;
  logic                           cfg_wr;
  logic                           out_load;

  assign in_fire = in_valid && in_ready;
  assign in_ready = state_r == ST_IDLE;

  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[MAF_ADDR_W-1:2] == MAF_REG_WINDOW_LENGTH);

  always_comb begin
    if (paddr[MAF_ADDR_W-1:2] == MAF_REG_WINDOW_LENGTH) begin
      prdata = MAF_APB_DW'(window_length_r);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= MAF_LEN_RESET;
    end else if (cfg_wr) begin
      window_length_r <= pwdata[MAF_CNT_W-1:0];
    end
  end

  // window length taken on clear, zero means one, capped at store depth and at the count width's maximum
  always_comb begin
    if (window_length_r == '0) begin
      len_latched = MAF_CNT_W'(1);
    end else if (32'(window_length_r) > CNT_MAX) begin
      len_latched = MAF_CNT_W'(CNT_MAX);
    end else begin
      len_latched = window_length_r;
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    rd_data_r <= store_r[ptr_r];
    if (state_r == ST_UPD) begin
      store_r[ptr_r] <= sample_r;
    end
  end

  // slots past the fill count are unwritten since clear and read as zero
  assign old_entry = (count_r == active_len_r) ? rd_data_r : '0;
  assign ptr_inc   = CMP_W'(ptr_r) + CMP_W'(1);
  assign sum_mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign quo_low   = div_quo[MAF_SAMPLE_W-1:0];
  assign div_start = state_r == ST_START;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  maf_div #(
    .DVD_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    active_len_nxt = active_len_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    sum_nxt        = sum_r;
    sample_nxt     = sample_r;
    avg_nxt        = avg_r;
    neg_nxt        = neg_r;
    out_item_nxt   = out_item_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_item.kind == MAF_KIND_CLEAR) begin
            active_len_nxt = len_latched;
            count_nxt      = '0;
            ptr_nxt        = '0;
            sum_nxt        = '0;
            avg_nxt        = '0;
            state_nxt      = ST_FIN;
          end else begin
            sample_nxt = in_item.sample;
            state_nxt  = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        sum_nxt = sum_r + SUM_W'(sample_r) - SUM_W'(old_entry);
        if (ptr_inc >= CMP_W'(active_len_r)) begin
          ptr_nxt = '0;
        end else begin
          ptr_nxt = ptr_inc[PTR_W-1:0];
        end
        if (count_r < active_len_r) begin
          count_nxt = count_r + MAF_CNT_W'(1);
        end
        state_nxt = ST_START;
      end
      ST_START: begin
        neg_nxt   = sum_r[SUM_W-1];
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          avg_nxt   = neg_r ? -quo_low : quo_low;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_item_nxt.average      = avg_r;
          out_item_nxt.window_full  = count_r == active_len_r;
          out_item_nxt.samples_held = count_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      active_len_r <= MAF_LEN_RESET;
      count_r      <= '0;
      ptr_r        <= '0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_len_r <= active_len_nxt;
      count_r      <= count_nxt;
      ptr_r        <= ptr_nxt;
      sum_r        <= sum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    avg_r      <= avg_nxt;
    neg_r      <= neg_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `MAF_ASSERT_SAME(a_count_in_window, clk, rst_n, 1'b1, count_r <= active_len_r)
  `MAF_ASSERT_SAME(a_ptr_in_window, clk, rst_n, 1'b1, CMP_W'(ptr_r) < CMP_W'(active_len_r))
  `MAF_ASSERT_NEXT(a_clear_empties, clk, rst_n, in_fire && in_item.kind == MAF_KIND_CLEAR, count_r == '0 && ptr_r == '0 && sum_r == '0)
  `MAF_ASSERT_SAME(a_div_done_in_div, clk, rst_n, div_done, state_r == ST_DIV)

endmodule
